// ----- rtl/core/rmst_pkg.sv -----
// Shared types and constants of the range maximum segment tree.
// No dependencies; every other file of the block uses it.
package rmst_pkg;

  localparam int LEAVES_DEF = 1024;
  localparam int ELEM_W     = 11;
  localparam int POS_W      = 11;
  localparam int VAL_W      = 32;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // result of a range that covers no leaf
  localparam logic signed [VAL_W-1:0] EMPTY_MAX = -32'sd1000000000;

  typedef logic signed [VAL_W-1:0] value_t;

endpackage

// ----- rtl/core/rmst_if.sv -----
// Valid/ready channel interfaces for requests and results.
// Depends on rmst_pkg for field widths.
interface rmst_in_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [rmst_pkg::POS_W-1:0]   position_or_left;
  logic [rmst_pkg::POS_W-1:0]   right_bound;
  logic signed [rmst_pkg::VAL_W-1:0] new_value;

  modport source (output valid, command, position_or_left, right_bound, new_value,
                  input ready);
  modport sink   (input valid, command, position_or_left, right_bound, new_value,
                  output ready);
endinterface

interface rmst_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rmst_pkg::VAL_W-1:0] max_value;

  modport source (output valid, max_value, input ready);
  modport sink   (input valid, max_value, output ready);
endinterface

// ----- rtl/core/range_max_segment_tree_top.sv -----
// Range maximum segment tree: top level with the walk sequencer.
// Depends on rmst_pkg, rmst_if, rmst_ram and rmst_max.

// A binary max-tree over P leaves lives in one memory of 2*LEAVES words, where P is the
// smallest power of two at least the element count (at most LEAVES, at least 1); node 1
// is the root and leaves sit at nodes P..2P-1. A request is either an update (command 0:
// store new_value at 1-based position_or_left, ignored if the position is zero or past P)
// or a query (command 1: maximum over the 1-based half-open range [position_or_left,
// right_bound), clipped to the tree, -1000000000 if it covers no leaf). The block handles
// one request at a time and holds in_chan.ready low while it works. The memory has one
// read and one write port with registered read data, and a single max unit serves every
// level, so cost is set by memory reads: an update writes the leaf, then per level reads
// the sibling and writes the parent, and ends with a step that finds the root; a query
// takes a low-bound step and a high-bound step per level walked, after its acceptance
// and before a final bound check and the result load, and waits longer while the
// output register still holds an unaccepted result. An update returns nothing; a query
// returns one result through an output register, so the next request is taken while
// that result waits. After reset and after every write of the element count the whole
// memory is cleared one word per cycle, and no request is taken meanwhile.
module range_max_segment_tree_top #(
  parameter int LEAVES = rmst_pkg::LEAVES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rmst_pkg::ELEM_W-1:0] cfg_wdata,
  rmst_in_if.sink                     in_chan,
  rmst_out_if.source                  out_chan
);

  localparam int DEPTH = 2 * LEAVES;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = AW + 1;                 // node index incl. one-past-end bound
  localparam int PW    = $clog2(LEAVES) + 1;     // padded leaf count
  localparam int CW    = (NW > 13) ? NW : 13;    // wide enough for any bound compare

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_U_READ,
    S_U_WRITE,
    S_Q_LO,
    S_Q_HI,
    S_Q_OUT
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [PW-1:0]     padded_r, padded_nxt;
  logic [NW-1:0]     lo_r, lo_nxt;           // also the current node of an update
  logic [NW-1:0]     hi_r, hi_nxt;
  rmst_pkg::value_t  cur_r, cur_nxt;         // value just written on the update path
  rmst_pkg::value_t  acc_r, acc_nxt;
  logic              any_r, any_nxt;
  logic              pend_r, pend_nxt;       // read data arrives this cycle
  logic              out_valid_r, out_valid_nxt;
  rmst_pkg::value_t  out_data_r, out_data_nxt;

  // memory port controls
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  rmst_pkg::value_t  mem_wdata;
  logic [AW-1:0]     mem_raddr;
  rmst_pkg::value_t  mem_rdata;

  // shared max unit
  rmst_pkg::value_t  max_a;
  rmst_pkg::value_t  max_y;

  // request decode in CW bits; the walk helpers hi_dec and parent are NW bits
  logic [CW-1:0]     pad_wide;
  logic [CW-1:0]     padded_w;
  logic [CW-1:0]     p_w, r_w;
  logic [CW-1:0]     q_lo, q_hi;
  logic [CW-1:0]     upd_node, lo_start, hi_start;
  logic              upd_ok;
  logic [NW-1:0]     hi_dec;
  logic [NW-1:0]     parent;

  rmst_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // On the update path combine the written child with its sibling; otherwise fold
  // the arriving word into the query accumulator.
  assign max_a = (state_r == S_U_WRITE) ? cur_r : acc_r;

  rmst_max u_max (
    .a (max_a),
    .b (mem_rdata),
    .y (max_y)
  );

  // Padded leaf count for a new element count: smallest power of two not below it,
  // capped at LEAVES; a zero count gives a single leaf.
  always_comb begin
    pad_wide = CW'(1) << 12;
    for (int k = 11; k >= 0; k--) begin
      if ((CW'(1) << k) >= CW'(cfg_wdata)) begin
        pad_wide = CW'(1) << k;
      end
    end
    if (pad_wide > CW'(LEAVES)) begin
      pad_wide = CW'(LEAVES);
    end
  end

  assign padded_w = CW'(padded_r);
  assign p_w      = CW'(in_chan.position_or_left);
  assign r_w      = CW'(in_chan.right_bound);
  assign q_lo     = (p_w == '0) ? CW'(1) : p_w;
  assign q_hi     = (r_w > padded_w + CW'(1)) ? padded_w + CW'(1) : r_w;
  assign upd_ok   = (p_w != '0) && (p_w <= padded_w);
  assign upd_node = p_w + padded_w - CW'(1);
  assign lo_start = q_lo + padded_w - CW'(1);
  assign hi_start = q_hi + padded_w - CW'(1);
  assign hi_dec   = hi_r - NW'(1);
  assign parent   = lo_r >> 1;

  assign in_chan.ready    = (state_r == S_IDLE);
  assign out_chan.valid   = out_valid_r;
  assign out_chan.max_value = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    padded_nxt    = padded_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    cur_nxt       = cur_r;
    acc_nxt       = acc_r;
    any_nxt       = any_r;
    pend_nxt      = 1'b0;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_raddr     = '0;

    // fold a word read in the previous cycle into the running maximum
    if (pend_r) begin
      acc_nxt = any_r ? max_y : mem_rdata;
      any_nxt = 1'b1;
    end

    unique case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_chan.valid) begin
          if (in_chan.command == rmst_pkg::CMD_UPDATE) begin
            // write the leaf, then climb; drop out-of-range positions
            if (upd_ok) begin
              mem_we    = 1'b1;
              mem_waddr = upd_node[AW-1:0];
              mem_wdata = in_chan.new_value;
              lo_nxt    = upd_node[NW-1:0];
              cur_nxt   = in_chan.new_value;
              state_nxt = S_U_READ;
            end
          end else begin
            any_nxt = 1'b0;
            if (q_lo < q_hi) begin
              lo_nxt    = lo_start[NW-1:0];
              hi_nxt    = hi_start[NW-1:0];
              state_nxt = S_Q_LO;
            end else begin
              state_nxt = S_Q_OUT;
            end
          end
        end
      end

      S_U_READ: begin
        if (lo_r < NW'(2)) begin
          state_nxt = S_IDLE;
        end else begin
          mem_raddr = lo_r[AW-1:0] ^ AW'(1);
          state_nxt = S_U_WRITE;
        end
      end

      S_U_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = parent[AW-1:0];
        mem_wdata = max_y;
        cur_nxt   = max_y;
        lo_nxt    = parent;
        state_nxt = S_U_READ;
      end

      S_Q_LO: begin
        if (lo_r < hi_r) begin
          if (lo_r[0]) begin
            mem_raddr = lo_r[AW-1:0];
            pend_nxt  = 1'b1;
            lo_nxt    = lo_r + NW'(1);
          end
          state_nxt = S_Q_HI;
        end else begin
          state_nxt = S_Q_OUT;
        end
      end

      S_Q_HI: begin
        if (hi_r[0]) begin
          mem_raddr = hi_dec[AW-1:0];
          pend_nxt  = 1'b1;
        end
        lo_nxt    = lo_r >> 1;
        hi_nxt    = hi_r >> 1;
        state_nxt = S_Q_LO;
      end

      S_Q_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = any_r ? acc_r : rmst_pkg::EMPTY_MAX;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // a new element count resizes the tree and restarts the clearing sweep
    if (cfg_we) begin
      padded_nxt  = pad_wide[PW-1:0];
      clr_cnt_nxt = '0;
      state_nxt   = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      padded_r    <= PW'(LEAVES);
      lo_r        <= '0;
      hi_r        <= '0;
      cur_r       <= '0;
      acc_r       <= '0;
      any_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      padded_r    <= padded_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      cur_r       <= cur_nxt;
      acc_r       <= acc_nxt;
      any_r       <= any_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

endmodule

// ----- rtl/core/rmst_ram.sv -----
// Single-write, single-read tree store with registered read data.
// Depends on rmst_pkg for the value type.
module rmst_ram #(
  parameter int DEPTH = 2 * rmst_pkg::LEAVES_DEF
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [$clog2(DEPTH)-1:0]  waddr,
  input  rmst_pkg::value_t          wdata,
  input  logic [$clog2(DEPTH)-1:0]  raddr,
  output rmst_pkg::value_t          rdata
);

  rmst_pkg::value_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/rmst_max.sv -----
// Shared signed maximum unit used by both the update and query walks.
// Depends on rmst_pkg for the value type.
module rmst_max (
  input  rmst_pkg::value_t a,
  input  rmst_pkg::value_t b,
  output rmst_pkg::value_t y
);

  assign y = (a > b) ? a : b;

endmodule
